[hw/rtl/mbrtu_pkg.sv]
// Shared types, constants and helper functions for the Modbus RTU read-holding slave.
package mbrtu_pkg;

    // Register file and frame limits
    localparam int unsigned NUM_REGS    = 8;
    localparam int unsigned REG_IDX_W   = $clog2(NUM_REGS);
    localparam int unsigned REG_CNT_W   = $clog2(NUM_REGS + 1);
    localparam int unsigned FRAME_BYTES = 256;
    localparam int unsigned BYTE_CNT_W  = $clog2(FRAME_BYTES + 1);
    localparam int unsigned HEADER_LEN  = 6;
    localparam int unsigned MIN_REQUEST = 8;
    localparam int unsigned POS_W       = $clog2(2 * NUM_REGS + 5);

    // Protocol constants
    localparam logic [15:0] CRC_SEED          = 16'hFFFF;
    localparam logic [15:0] CRC_POLY          = 16'hA001;
    localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;

    // Item kinds on the input stream (tuser)
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] CFG_SLAVE_ADDR    = 2'd0;
    localparam logic [1:0] CFG_SILENCE_TICKS = 2'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RX_CRC,
        S_JUDGE,
        S_EMIT,
        S_TX_CRC
    } t_state;

    // One bit step of the reflected CRC-16
    function automatic logic [15:0] f_crc_step(input logic [15:0] crc);
        logic [15:0] sh;
        sh = crc >> 1;
        return crc[0] ? (sh ^ CRC_POLY) : sh;
    endfunction

    // Fixed holding register contents: 100 * (index + 1)
    function automatic logic [15:0] f_holding(input logic [REG_IDX_W-1:0] idx);
        logic [31:0] v;
        v = (32'(idx) + 32'd1) * 32'd100;
        return v[15:0];
    endfunction

endpackage

[hw/rtl/modbus_rtu_read_holding_slave_core.sv]
// Modbus RTU slave core answering function 0x03 (read holding registers).
//
// Channel   Dir  Handshake                    Payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata: rx_data[7:0]; tuser: op (0 byte, 1 tick)
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: tx_data[7:0]; tlast: last_byte
// cfg       in   i_cfg_we (no wait)           i_cfg_idx register index, i_cfg_data value
//
// A received byte is accepted, then folded into the CRC in 8 single-bit steps.
// A tick that ends a frame leads to the judge state; a valid request is answered
// with up to 21 reply bytes, each byte ahead of the CRC followed by 8 single-bit
// CRC steps (bitwise CRC over the shared CRC register). Input waits outside idle.
// Reply bytes wait in the output register while m_axis_tready is low; the CRC
// sequencer stalls behind it. Synchronous active-low reset, no clearing pass.
module modbus_rtu_read_holding_slave_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input stream
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] rx_data
    input  logic       s_axis_tuser,   // [0] op
    // output stream
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] tx_data
    output logic       m_axis_tlast,
    // configuration
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data
);
    import mbrtu_pkg::*;

    t_state r_state, n_state;

    logic [7:0]            r_slave_addr;
    logic [7:0]            r_silence;
    logic [7:0]            r_hdr [HEADER_LEN];
    logic [BYTE_CNT_W-1:0] r_bytes, n_bytes;
    logic [15:0]           r_crc, n_crc;
    logic [7:0]            r_quiet, n_quiet;
    logic [2:0]            r_bit, n_bit;
    logic [REG_IDX_W-1:0]  r_start, n_start;
    logic [REG_CNT_W-1:0]  r_count, n_count;
    logic [POS_W-1:0]      r_pos, n_pos;
    logic                  r_out_valid, n_out_valid;
    logic [7:0]            r_out_data, n_out_data;
    logic                  r_out_last, n_out_last;

    logic                  w_in_acc;
    logic                  w_out_free;
    logic [7:0]            w_quiet_inc;
    logic                  w_end_frame;
    logic [15:0]           w_req_start;
    logic [15:0]           w_req_count;
    logic [16:0]           w_req_end;
    logic                  w_req_ok;
    logic [POS_W-1:0]      w_crc_lo_pos;
    logic [POS_W-1:0]      w_rel;
    logic [REG_IDX_W-1:0]  w_reg_idx;
    logic [15:0]           w_reg_val;
    logic                  w_is_lo;
    logic                  w_is_hi;
    logic [7:0]            w_tx_byte;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

    // Silence count and end-of-frame detect
    assign w_quiet_inc = (r_quiet == 8'hFF) ? r_quiet : r_quiet + 8'd1;
    assign w_end_frame = (r_bytes != '0) && (w_quiet_inc >= r_silence);

    // Request check
    assign w_req_start = {r_hdr[2], r_hdr[3]};
    assign w_req_count = {r_hdr[4], r_hdr[5]};
    assign w_req_end   = {1'b0, w_req_start} + {1'b0, w_req_count};
    assign w_req_ok    = (r_bytes >= BYTE_CNT_W'(MIN_REQUEST)) && (r_crc == 16'h0000)
                      && (r_hdr[0] == r_slave_addr) && (r_hdr[1] == FUNC_READ_HOLDING)
                      && (w_req_count != 16'h0000) && (w_req_end <= 17'(NUM_REGS));

    // Reply byte selection
    assign w_crc_lo_pos = POS_W'(3) + POS_W'({r_count, 1'b0});
    assign w_rel        = r_pos - POS_W'(3);
    assign w_reg_idx    = r_start + w_rel[REG_IDX_W:1];
    assign w_reg_val    = f_holding(w_reg_idx);
    assign w_is_lo      = (r_pos == w_crc_lo_pos);
    assign w_is_hi      = (r_pos == w_crc_lo_pos + POS_W'(1));

    always_comb begin
        priority if (r_pos == POS_W'(0)) begin
            w_tx_byte = r_slave_addr;
        end else if (r_pos == POS_W'(1)) begin
            w_tx_byte = FUNC_READ_HOLDING;
        end else if (r_pos == POS_W'(2)) begin
            w_tx_byte = 8'({r_count, 1'b0});
        end else if (w_is_lo) begin
            w_tx_byte = r_crc[7:0];
        end else if (w_is_hi) begin
            w_tx_byte = r_crc[15:8];
        end else begin
            w_tx_byte = w_rel[0] ? w_reg_val[7:0] : w_reg_val[15:8];
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (s_axis_tuser == OP_BYTE) begin
                        if (r_bytes != BYTE_CNT_W'(FRAME_BYTES)) begin
                            n_state = S_RX_CRC;
                        end
                    end else if (w_end_frame) begin
                        n_state = S_JUDGE;
                    end
                end
            end
            S_RX_CRC: begin
                if (r_bit == 3'd7) begin
                    n_state = S_IDLE;
                end
            end
            S_JUDGE: begin
                n_state = w_req_ok ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    if (w_is_hi) begin
                        n_state = S_IDLE;
                    end else if (!w_is_lo) begin
                        n_state = S_TX_CRC;
                    end
                end
            end
            S_TX_CRC: begin
                if (r_bit == 3'd7) begin
                    n_state = S_EMIT;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath next values
    always_comb begin
        n_bytes     = r_bytes;
        n_crc       = r_crc;
        n_quiet     = r_quiet;
        n_bit       = r_bit;
        n_start     = r_start;
        n_count     = r_count;
        n_pos       = r_pos;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_data  = r_out_data;
        n_out_last  = r_out_last;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    if (s_axis_tuser == OP_BYTE) begin
                        n_quiet = 8'h00;
                        if (r_bytes != BYTE_CNT_W'(FRAME_BYTES)) begin
                            n_bytes = r_bytes + BYTE_CNT_W'(1);
                            n_crc   = r_crc ^ {8'h00, s_axis_tdata};
                            n_bit   = 3'd0;
                        end else begin
                            n_bytes = '0;
                            n_crc   = CRC_SEED;
                        end
                    end else begin
                        n_quiet = w_quiet_inc;
                    end
                end
            end
            S_RX_CRC, S_TX_CRC: begin
                n_crc = f_crc_step(r_crc);
                n_bit = r_bit + 3'd1;
            end
            S_JUDGE: begin
                // frame is cleared either way; the CRC register is reused for the reply
                n_bytes = '0;
                n_crc   = CRC_SEED;
                n_start = w_req_start[REG_IDX_W-1:0];
                n_count = w_req_count[REG_CNT_W-1:0];
                n_pos   = '0;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = w_tx_byte;
                    n_out_last  = w_is_hi;
                    n_pos       = r_pos + POS_W'(1);
                    if (w_is_hi) begin
                        n_crc = CRC_SEED;
                    end else if (!w_is_lo) begin
                        n_crc = r_crc ^ {8'h00, w_tx_byte};
                        n_bit = 3'd0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_slave_addr <= 8'd1;
            r_silence    <= 8'd2;
            r_bytes      <= '0;
            r_crc        <= CRC_SEED;
            r_quiet      <= 8'h00;
            r_bit        <= 3'd0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_bytes     <= n_bytes;
            r_crc       <= n_crc;
            r_quiet     <= n_quiet;
            r_bit       <= n_bit;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_SLAVE_ADDR) begin
                    r_slave_addr <= i_cfg_data;
                end else if (i_cfg_idx == CFG_SILENCE_TICKS) begin
                    r_silence <= i_cfg_data;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_start    <= n_start;
        r_count    <= n_count;
        r_pos      <= n_pos;
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
        if (w_in_acc && (s_axis_tuser == OP_BYTE)
                && (r_bytes < BYTE_CNT_W'(HEADER_LEN))) begin
            r_hdr[r_bytes[$clog2(HEADER_LEN)-1:0]] <= s_axis_tdata;
        end
    end

    // Checks
    a_judge_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_JUDGE |=> r_bytes == '0 && r_crc == CRC_SEED)
        else $error("frame not cleared after judge");

    a_emit_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT |-> r_pos <= w_crc_lo_pos + POS_W'(1))
        else $error("reply position past end of frame");

    a_rx_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_RX_CRC |-> r_bytes != '0)
        else $error("CRC fold without a counted byte");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT && w_out_free && w_is_hi |=> r_state == S_IDLE && r_out_last)
        else $error("last reply byte did not end the reply");

endmodule

[tb/modbus_rtu_read_holding_slave_core_tb.sv]
// Self-checking testbench for the Modbus RTU read-holding-registers slave core.
`timescale 1ns / 1ps

module modbus_rtu_read_holding_slave_core_tb;
    import mbrtu_pkg::*;

    // Unused register indexes, writes there must leave the block unchanged
    localparam logic [1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [1:0] CFG_SPARE_3 = 2'd3;

    localparam int SETTLE_CYCLES = 24;
    localparam int DRAIN_CYCLES  = 200;
    localparam int CYCLE_LIMIT   = 2_000_000;
    localparam int RANDOM_ITEMS  = 30;
    localparam int REPORT_MAX    = 10;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } t_tx_byte;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;  // [7:0] rx_data
    logic       s_axis_tuser  = 1'b0;   // [0] op
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [7:0] tx_data
    logic       m_axis_tlast;
    logic       i_cfg_we      = 1'b0;
    logic [1:0] i_cfg_idx     = 2'd0;
    logic [7:0] i_cfg_data    = 8'h00;

    modbus_rtu_read_holding_slave_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Slave model state
    logic [7:0]  m_addr;
    logic [7:0]  m_silence;
    logic [7:0]  m_hdr [HEADER_LEN];
    int unsigned m_count;
    logic [15:0] m_crc;
    logic [7:0]  m_quiet;
    logic [15:0] reply_crc;

    t_tx_byte    tx_expect_q [$];
    logic [7:0]  req_bytes [$];

    int  fail_cnt   = 0;
    int  items_sent = 0;
    int  cycle_cnt  = 0;
    bit  no_idle    = 1'b0;

    // Reflected CRC-16 over one byte, LSB first
    function automatic logic [15:0] crc16_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        return c;
    endfunction

    function automatic logic [15:0] holding_word(input int unsigned idx);
        return 16'(100 * (idx + 1));
    endfunction

    function automatic void model_clear_frame();
        m_count = 0;
        m_crc   = CRC_SEED;
        for (int k = 0; k < HEADER_LEN; k++)
            m_hdr[k] = 8'h00;
    endfunction

    // Queue one reply byte and fold it into the reply CRC
    function automatic void emit_reply_byte(input logic [7:0] b);
        t_tx_byte t;
        reply_crc = crc16_fold(reply_crc, b);
        t.data = b;
        t.last = 1'b0;
        tx_expect_q.push_back(t);
    endfunction

    function automatic void model_judge_frame();
        int unsigned first;
        int unsigned cnt;
        logic [15:0] word;
        t_tx_byte    t;
        if (m_count < MIN_REQUEST || m_crc != 16'h0000 || m_hdr[0] != m_addr ||
            m_hdr[1] != FUNC_READ_HOLDING)
            return;
        first = {16'h0000, m_hdr[2], m_hdr[3]};
        cnt   = {16'h0000, m_hdr[4], m_hdr[5]};
        if (cnt == 0 || first + cnt > NUM_REGS)
            return;
        reply_crc = CRC_SEED;
        emit_reply_byte(m_addr);
        emit_reply_byte(FUNC_READ_HOLDING);
        emit_reply_byte(8'(cnt * 2));
        for (int unsigned k = 0; k < cnt; k++) begin
            word = holding_word(first + k);
            emit_reply_byte(word[15:8]);
            emit_reply_byte(word[7:0]);
        end
        t.data = reply_crc[7:0];
        t.last = 1'b0;
        tx_expect_q.push_back(t);
        t.data = reply_crc[15:8];
        t.last = 1'b1;
        tx_expect_q.push_back(t);
    endfunction

    // Update the model with one accepted input transaction
    function automatic void model_rx_item(input logic op, input logic [7:0] data);
        if (op == OP_BYTE) begin
            m_quiet = 8'h00;
            if (m_count < FRAME_BYTES) begin
                if (m_count < HEADER_LEN)
                    m_hdr[m_count] = data;
                m_count++;
                m_crc = crc16_fold(m_crc, data);
            end else begin
                model_clear_frame();
            end
        end else begin
            if (m_quiet != 8'hFF)
                m_quiet++;
            if (m_count > 0 && m_quiet >= m_silence) begin
                model_judge_frame();
                model_clear_frame();
            end
        end
    endfunction

    // Idle length: mostly short, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Output side: random backpressure and result checking
    int       stall_left = 0;
    t_tx_byte got;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (tx_expect_q.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= REPORT_MAX)
                        $display("unexpected reply byte: data=%02h last=%b",
                                 m_axis_tdata, m_axis_tlast);
                end else begin
                    got = tx_expect_q.pop_front();
                    if (m_axis_tdata !== got.data) begin
                        fail_cnt++;
                        if (fail_cnt <= REPORT_MAX)
                            $display("tx_data mismatch: expected %02h actual %02h",
                                     got.data, m_axis_tdata);
                    end
                    if (m_axis_tlast !== got.last) begin
                        fail_cnt++;
                        if (fail_cnt <= REPORT_MAX)
                            $display("last_byte mismatch: expected %b actual %b",
                                     got.last, m_axis_tlast);
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (!no_idle && $urandom_range(0, 99) < 20) begin
                stall_left = idle_len() - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Send one item and update the model once the transaction completes
    task automatic send_item(input logic op, input logic [7:0] data);
        int gap;
        gap = (no_idle || $urandom_range(0, 99) < 55) ? 0 : idle_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= data;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        model_rx_item(op, data);
        items_sent++;
    endtask

    task automatic send_tick();
        send_item(OP_TICK, 8'($urandom));
    endtask

    // Drop valid and wait until every expected reply byte is out
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (tx_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [7:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_SLAVE_ADDR:    m_addr    = value;
            CFG_SILENCE_TICKS: m_silence = value;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // Build a request header into req_bytes; append_crc adds the CRC low byte first
    task automatic build_request(input logic [7:0] addr, input logic [7:0] func,
                                 input logic [15:0] first, input logic [15:0] cnt);
        req_bytes.delete();
        req_bytes.push_back(addr);
        req_bytes.push_back(func);
        req_bytes.push_back(first[15:8]);
        req_bytes.push_back(first[7:0]);
        req_bytes.push_back(cnt[15:8]);
        req_bytes.push_back(cnt[7:0]);
    endtask

    task automatic append_crc();
        logic [15:0] c;
        c = CRC_SEED;
        foreach (req_bytes[k])
            c = crc16_fold(c, req_bytes[k]);
        req_bytes.push_back(c[7:0]);
        req_bytes.push_back(c[15:8]);
    endtask

    // Send req_bytes, sometimes with pauses shorter than the silence threshold
    task automatic send_frame_bytes(input bit allow_pauses);
        int n;
        foreach (req_bytes[k]) begin
            send_item(OP_BYTE, req_bytes[k]);
            if (allow_pauses && m_silence >= 2 && $urandom_range(0, 99) < 8) begin
                n = (m_silence <= 8) ? $urandom_range(1, m_silence - 1) : m_silence - 1;
                repeat (n) send_tick();
            end
        end
    endtask

    // Enough silence to end the frame, plus a few spare ticks
    task automatic close_frame();
        repeat ((m_silence == 0) ? 1 : m_silence) send_tick();
        repeat ($urandom_range(0, 2)) send_tick();
    endtask

    task automatic send_request(input logic [7:0] addr, input logic [15:0] first,
                                input logic [15:0] cnt);
        build_request(addr, FUNC_READ_HOLDING, first, cnt);
        append_crc();
        send_frame_bytes(1'b1);
        close_frame();
    endtask

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // Reset settings: widest read, last register alone, idle tick
    task automatic test_default_read();
        send_tick();
        send_request(8'h01, 16'd0, 16'(NUM_REGS));
        send_request(8'h01, 16'(NUM_REGS - 1), 16'd1);
        wait_idle();
    endtask

    // Each reason for silently dropping a frame
    task automatic test_drop_cases();
        // short frame: a valid request cut to seven bytes
        build_request(m_addr, FUNC_READ_HOLDING, 16'd0, 16'd2);
        append_crc();
        void'(req_bytes.pop_back());
        send_frame_bytes(1'b0);
        close_frame();
        // corrupted CRC
        build_request(m_addr, FUNC_READ_HOLDING, 16'd1, 16'd3);
        append_crc();
        req_bytes[7] = req_bytes[7] ^ 8'h80;
        send_frame_bytes(1'b0);
        close_frame();
        send_request(m_addr ^ 8'h40, 16'd0, 16'd1);
        build_request(m_addr, 8'h04, 16'd0, 16'd1);
        append_crc();
        send_frame_bytes(1'b0);
        close_frame();
        send_request(m_addr, 16'd0, 16'd0);
        send_request(m_addr, 16'(NUM_REGS - 1), 16'd2);
        // start plus count must not wrap
        send_request(m_addr, 16'hFFFF, 16'd1);
        send_request(m_addr, 16'd0, 16'hFFFF);
        wait_idle();
    endtask

    // Bytes past the header only feed the CRC
    task automatic test_long_frame();
        build_request(m_addr, FUNC_READ_HOLDING, 16'd2, 16'd4);
        repeat (3) req_bytes.push_back(8'($urandom));
        append_crc();
        send_frame_bytes(1'b1);
        close_frame();
        wait_idle();
    endtask

    // Buffer filled exactly, one byte over drops the frame, then recovery
    task automatic test_full_buffer();
        build_request(m_addr, FUNC_READ_HOLDING, 16'd3, 16'd5);
        while (req_bytes.size() < FRAME_BYTES - 2)
            req_bytes.push_back(8'($urandom));
        append_crc();
        send_frame_bytes(1'b0);
        // the extra byte is discarded along with the held frame
        send_item(OP_BYTE, 8'($urandom));
        send_request(m_addr, 16'd3, 16'd5);
        wait_idle();
    endtask

    // Address and silence extremes, spare register indexes
    task automatic test_config_extremes();
        cfg_write(CFG_SLAVE_ADDR, 8'h00);
        cfg_write(CFG_SILENCE_TICKS, 8'd0);
        send_request(8'h00, 16'd0, 16'd1);
        wait_idle();
        cfg_write(CFG_SLAVE_ADDR, 8'hFF);
        cfg_write(CFG_SILENCE_TICKS, 8'd1);
        send_request(8'hFF, 16'd6, 16'd2);
        send_request(8'h01, 16'd0, 16'd1);
        wait_idle();
        cfg_write(CFG_SPARE_2, 8'($urandom));
        cfg_write(CFG_SPARE_3, 8'($urandom));
        send_request(8'hFF, 16'd4, 16'd1);
        wait_idle();
        cfg_write(CFG_SLAVE_ADDR, 8'h01);
        cfg_write(CFG_SILENCE_TICKS, 8'd2);
    endtask

    // One random frame: mostly valid requests, plus broken ones and noise
    task automatic random_frame();
        int          r;
        logic [15:0] first;
        logic [15:0] cnt;
        logic [7:0]  func;
        r = $urandom_range(0, 99);
        first = 16'($urandom_range(0, NUM_REGS - 1));
        cnt   = 16'($urandom_range(1, NUM_REGS - first));
        if (r < 55) begin
            send_request(m_addr, first, cnt);
        end else if (r < 62) begin
            build_request(m_addr, FUNC_READ_HOLDING, first, cnt);
            repeat ($urandom_range(1, 6)) req_bytes.push_back(8'($urandom));
            append_crc();
            send_frame_bytes(1'b1);
            close_frame();
        end else if (r < 68) begin
            build_request(m_addr, FUNC_READ_HOLDING, first, cnt);
            append_crc();
            r = $urandom_range(0, req_bytes.size() - 1);
            req_bytes[r] = req_bytes[r] ^ 8'(1 << $urandom_range(0, 7));
            send_frame_bytes(1'b1);
            close_frame();
        end else if (r < 72) begin
            send_request(m_addr ^ 8'($urandom_range(1, 255)), first, cnt);
        end else if (r < 76) begin
            func = 8'($urandom);
            if (func == FUNC_READ_HOLDING)
                func = ~func;
            build_request(m_addr, func, first, cnt);
            append_crc();
            send_frame_bytes(1'b1);
            close_frame();
        end else if (r < 80) begin
            send_request(m_addr, 16'($urandom), 16'd0);
        end else if (r < 85) begin
            first = 16'($urandom);
            cnt   = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(1, 130))
                                                : 16'($urandom_range(1, 65535));
            if (32'(first) + 32'(cnt) <= NUM_REGS)
                first = 16'(NUM_REGS);
            send_request(m_addr, first, cnt);
        end else if (r < 90) begin
            req_bytes.delete();
            repeat ($urandom_range(1, MIN_REQUEST - 1)) req_bytes.push_back(8'($urandom));
            send_frame_bytes(1'b0);
            close_frame();
        end else if (r < 95) begin
            repeat ($urandom_range(1, 5)) send_tick();
        end else begin
            req_bytes.delete();
            repeat ($urandom_range(1, 20)) req_bytes.push_back(8'($urandom));
            send_frame_bytes(1'b1);
            close_frame();
        end
    endtask

    // Random phases, each with its own settings and idling behavior
    task automatic test_random_traffic();
        int base;
        int r;
        base = items_sent;
        while (items_sent - base < RANDOM_ITEMS) begin
            wait_idle();
            if ($urandom_range(0, 2) == 0)
                cfg_write(CFG_SLAVE_ADDR, 8'($urandom));
            r = $urandom_range(0, 99);
            if (r < 70)
                cfg_write(CFG_SILENCE_TICKS, 8'($urandom_range(0, 4)));
            else if (r < 95)
                cfg_write(CFG_SILENCE_TICKS, 8'($urandom_range(5, 12)));
            else
                cfg_write(CFG_SILENCE_TICKS, 8'($urandom_range(30, 60)));
            if ($urandom_range(0, 9) == 0)
                cfg_write(($urandom_range(0, 1) == 0) ? CFG_SPARE_2 : CFG_SPARE_3,
                          8'($urandom));
            no_idle = ($urandom_range(0, 4) == 0);
            repeat ($urandom_range(2, 5)) random_frame();
        end
        no_idle = 1'b0;
        wait_idle();
    endtask

    // Sequence
    initial begin
        m_addr    = 8'h01;
        m_silence = 8'd2;
        m_quiet   = 8'h00;
        model_clear_frame();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_read();
        test_drop_cases();
        test_long_frame();
        test_full_buffer();
        test_config_extremes();
        test_random_traffic();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
